// ===== rtl/kpmf_pkg.sv =====
// ----------------------------------------------------------------------------
// kpmf_pkg
// Shared widths, codes, types and a helper function of the k-mer partition
// mask filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kpmf_pkg;

    // Table geometry and partition limit.
    localparam int TABLE_BITS     = 16;
    localparam int MAX_PARTITIONS = 64;

    // Field widths.
    localparam int KMER_W   = 64;
    localparam int MASK_W   = 64;
    localparam int OP_W     = 2;
    localparam int PART_W   = 6;
    localparam int PCOUNT_W = 7;
    localparam int HBITS_W  = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // Hash shift amounts.
    localparam int HASH_SHR_A = 17;
    localparam int HASH_SHR_B = 37;
    localparam int HASH_SHL   = 11;

    typedef logic [OP_W-1:0]       op_t;
    typedef logic [MASK_W-1:0]     mask_t;
    typedef logic [TABLE_BITS-1:0] bucket_t;

    // Operation codes.
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_QUERY1 = 2'd1;
    localparam op_t OP_QUERY2 = 2'd2;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_BITS       = 1'd1;

    // Control bundle that drives the bucket memory.
    typedef struct packed {
        logic    wr_en;
        bucket_t wr_addr;
        mask_t   wr_data;
        logic    rd_en;
        bucket_t rd_addr;
    } tbl_ctrl_t;

    // Mask of the partitions in use; counts above the limit saturate.
    function automatic mask_t partition_limit(input logic [PCOUNT_W-1:0] count);
        mask_t lim;
        for (int i = 0; i < MASK_W; i++)
        begin
            lim[i] = (i < MAX_PARTITIONS) && (count > PCOUNT_W'(i));
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kpmf_if.sv =====
// ----------------------------------------------------------------------------
// kpmf_if
// Valid/ready channels of the filter: k-mer requests in, partition masks out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpmf_req_if;
    import kpmf_pkg::*;

    logic               valid;
    logic               ready;
    op_t                operation;
    logic [KMER_W-1:0]  kmer;
    logic [PART_W-1:0]  partition;
    logic               paired;
    logic               last_kmer;
    logic               no_kmer;

    modport source (
        output valid, operation, kmer, partition, paired, last_kmer, no_kmer,
        input  ready
    );

    modport sink (
        input  valid, operation, kmer, partition, paired, last_kmer, no_kmer,
        output ready
    );
endinterface

interface kpmf_rsp_if;
    import kpmf_pkg::*;

    logic  valid;
    logic  ready;
    mask_t both_reads_mask;
    mask_t first_alone_mask;
    mask_t second_alone_mask;

    modport source (
        output valid, both_reads_mask, first_alone_mask, second_alone_mask,
        input  ready
    );

    modport sink (
        input  valid, both_reads_mask, first_alone_mask, second_alone_mask,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/kpmf_hash.sv =====
// ----------------------------------------------------------------------------
// kpmf_hash
// Bucket index of a k-mer: xor of shifted copies, cut to the buckets in use.
// ----------------------------------------------------------------------------
`default_nettype none

module kpmf_hash (
    input  wire logic [kpmf_pkg::KMER_W-1:0]  kmer,
    input  wire logic [kpmf_pkg::HBITS_W-1:0] hash_bits,
    output      kpmf_pkg::bucket_t            bucket
);
    import kpmf_pkg::*;

    logic [KMER_W-1:0] mixed;
    bucket_t           use_mask;

    assign mixed = kmer ^ (kmer >> HASH_SHR_A) ^ (kmer >> HASH_SHR_B) ^ (kmer << HASH_SHL);

    // A hash width above the table width keeps every table bit.
    always_comb
    begin
        for (int i = 0; i < TABLE_BITS; i++)
        begin
            use_mask[i] = (hash_bits > HBITS_W'(i));
        end
    end

    assign bucket = mixed[TABLE_BITS-1:0] & use_mask;

endmodule

`default_nettype wire

// ===== rtl/kpmf_table.sv =====
// ----------------------------------------------------------------------------
// kpmf_table
// Bucket memory: one partition mask per bucket, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kpmf_table (
    input  wire logic                clk,
    input  wire kpmf_pkg::tbl_ctrl_t ctrl,
    output      kpmf_pkg::mask_t     rd_data
);
    import kpmf_pkg::*;

    localparam int DEPTH = 1 << TABLE_BITS;

    mask_t mem [DEPTH];
    mask_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/kmer_partition_mask_filter_core.sv =====
// Steps: a request with a k-mer passes accept, bucket read and update; one without a
// k-mer, or with operation three, is done at accept. A read group end adds an emit
// step, held while an earlier result waits, and its masks show in the cycle after it.
// Throughput: a request with a k-mer is done before the next is taken, as its bucket
// is read, then written back; one per cycle without a k-mer when no read group ends.
// Reset: all 65536 buckets are cleared, ready held low; configuration writes are taken.
// ----------------------------------------------------------------------------
// kmer_partition_mask_filter_core
// Hashed bucket table of partition masks with per-read accumulators and a
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_partition_mask_filter_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [kpmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kpmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    kpmf_req_if.sink                              request,
    kpmf_rsp_if.source                            result
);
    import kpmf_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_MODIFY = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    bucket_t             clr_addr_reg, clr_addr_next;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [HBITS_W-1:0]  hbits_reg;

    op_t                 op_reg;
    logic [KMER_W-1:0]   kmer_reg;
    logic [PART_W-1:0]   part_reg;
    logic                paired_reg;
    logic                ends_reg;

    mask_t               first_acc_reg, first_acc_next;
    mask_t               second_acc_reg, second_acc_next;

    logic                out_valid_reg, out_valid_next;
    mask_t               both_reg, first_alone_reg, second_alone_reg;

    bucket_t             bucket;
    mask_t               rd_data;
    tbl_ctrl_t           tbl_ctrl;
    logic                accept;
    logic                out_load;
    logic                group_end;
    mask_t               lim;
    mask_t               r2_eff;

    kpmf_hash u_hash (
        .kmer      (kmer_reg),
        .hash_bits (hbits_reg),
        .bucket    (bucket)
    );

    kpmf_table u_table (
        .clk     (clk),
        .ctrl    (tbl_ctrl),
        .rd_data (rd_data)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;

    // A query that ends read two, or ends read one of an unpaired read, closes the group.
    assign group_end = ends_reg &&
                       ((op_reg == OP_QUERY2) || ((op_reg == OP_QUERY1) && !paired_reg));

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || result.ready);
    assign lim      = partition_limit(pcount_reg);
    assign r2_eff   = (op_reg == OP_QUERY2) ? second_acc_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        tbl_ctrl        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                tbl_ctrl.wr_en   = 1'b1;
                tbl_ctrl.wr_addr = clr_addr_reg;
                tbl_ctrl.wr_data = '0;
                clr_addr_next    = clr_addr_reg + bucket_t'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.operation != OP_INSERT && request.operation != OP_QUERY1 &&
                        request.operation != OP_QUERY2)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!request.no_kmer)
                    begin
                        state_next = S_READ;
                    end
                    else if ((request.operation == OP_QUERY2) ||
                             ((request.operation == OP_QUERY1) && !request.paired))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_READ:
            begin
                tbl_ctrl.rd_en   = 1'b1;
                tbl_ctrl.rd_addr = bucket;
                state_next       = S_MODIFY;
            end
            S_MODIFY:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        tbl_ctrl.wr_en   = 1'b1;
                        tbl_ctrl.wr_addr = bucket;
                        tbl_ctrl.wr_data = rd_data | (MASK_W'(1) << part_reg);
                    end
                    OP_QUERY1:
                    begin
                        first_acc_next = first_acc_reg | rd_data;
                    end
                    OP_QUERY2:
                    begin
                        second_acc_next = second_acc_reg | rd_data;
                    end
                    default:
                    begin
                        first_acc_next = first_acc_reg;
                    end
                endcase
                state_next = group_end ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    first_acc_next  = '0;
                    second_acc_next = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            pcount_reg     <= PCOUNT_W'(MAX_PARTITIONS);
            hbits_reg      <= HBITS_W'(TABLE_BITS);
            first_acc_reg  <= '0;
            second_acc_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            first_acc_reg  <= first_acc_next;
            second_acc_reg <= second_acc_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PARTITION_COUNT: pcount_reg <= cfg_data[PCOUNT_W-1:0];
                    REG_HASH_BITS:       hbits_reg  <= cfg_data[HBITS_W-1:0];
                    default:             hbits_reg  <= hbits_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= request.operation;
            kmer_reg   <= request.kmer;
            part_reg   <= request.partition;
            paired_reg <= request.paired;
            ends_reg   <= request.last_kmer || request.no_kmer;
        end
        if (out_load)
        begin
            both_reg         <= first_acc_reg & r2_eff & lim;
            first_alone_reg  <= first_acc_reg & ~r2_eff & lim;
            second_alone_reg <= r2_eff & ~first_acc_reg & lim;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.both_reads_mask   = both_reg;
    assign result.first_alone_mask  = first_alone_reg;
    assign result.second_alone_mask = second_alone_reg;

    // The bucket memory is written only by the clearing sweep or an insert update.
    a_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctrl.wr_en |-> (state_reg == S_CLEAR || (state_reg == S_MODIFY && op_reg == OP_INSERT)))
        else $error("bucket memory written outside clear or insert update");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register loaded while a result is pending");

    // Closing a read group leaves both accumulators empty.
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (first_acc_reg == '0 && second_acc_reg == '0))
        else $error("accumulators not cleared after a read group");

    // A new result only follows the emit step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside the emit step");

endmodule

`default_nettype wire
